@@ hw/rtl/tns_pkg.sv @@
`default_nettype none
package tns_pkg;

	localparam int TUNE_DEPTH = 1024;
	localparam int TUNE_AW = $clog2(TUNE_DEPTH);
	localparam int NOTE_COUNT = 36;
	localparam int TABLE_LEN = 36;
	localparam logic [7:0] END_CODE = 8'd255;
	localparam logic [7:0] REST_CODE = 8'd254;
	localparam logic [4:0] ENV_AMP_CODE = 5'd16;
	localparam int MAX_WRITES = 18;
	localparam int WCNT_W = $clog2(MAX_WRITES + 1);

	localparam logic [3:0] REG_MIXER = 4'd7;
	localparam logic [3:0] REG_AMP0 = 4'd8;
	localparam logic [3:0] REG_ENV_LO = 4'd11;
	localparam logic [3:0] REG_ENV_HI = 4'd12;
	localparam logic [3:0] REG_SHAPE = 4'd13;

	localparam logic [2:0] CFG_TRACK0 = 3'd0;
	localparam logic [2:0] CFG_TRACK1 = 3'd1;
	localparam logic [2:0] CFG_TRACK2 = 3'd2;
	localparam logic [2:0] CFG_ENV_PERIOD = 3'd3;
	localparam logic [2:0] CFG_ENV_SHAPE = 3'd4;
	localparam logic [2:0] CFG_LOOP = 3'd5;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_LOAD = 2'd1,
		OP_PLAY = 2'd2,
		OP_STOP = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_TRK,
		S_NOTE,
		S_DUR,
		S_PLO,
		S_PHI,
		S_MIXON,
		S_AMP,
		S_SHAPE,
		S_SIL_AMP,
		S_SIL_MIX,
		S_END_CHK,
		S_PLAY11,
		S_PLAY12,
		S_PLAY13,
		S_DRAIN
	} state_t;

	localparam logic [11:0] PERIOD_TABLE [TABLE_LEN] = '{
		12'd478, 12'd451, 12'd426, 12'd402, 12'd379, 12'd358,
		12'd338, 12'd319, 12'd301, 12'd284, 12'd268, 12'd253,
		12'd239, 12'd225, 12'd213, 12'd201, 12'd190, 12'd179,
		12'd169, 12'd159, 12'd150, 12'd142, 12'd134, 12'd127,
		12'd119, 12'd113, 12'd106, 12'd100, 12'd95, 12'd89,
		12'd84, 12'd80, 12'd75, 12'd71, 12'd67, 12'd63
	};

	function automatic logic [11:0] tone_period(input logic [7:0] note);
		logic [11:0] per;
		per = '0;
		if (32'(note) < NOTE_COUNT && 32'(note) < TABLE_LEN) begin
			per = PERIOD_TABLE[note[$clog2(TABLE_LEN)-1:0]];
		end
		return per;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/three_track_note_sequencer.sv @@
// A tick while playing holds busy while one sequencer visits each track in turn, reads the
// tune memory and builds at most 15 chip writes, then the writes go out one per cycle with a
// strobe. Play and stop hold busy until their writes are out; a load or a tick while stopped
// completes at its accepting edge. A new request is taken in any cycle in which busy is low.
// The receiver cannot stall; busy stays high until the last write has been shown.
// Reset clears the control state and the registers; tune memory is undefined.
`default_nettype none
module three_track_note_sequencer import tns_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [9:0]  load_addr,
	input  wire logic [7:0]  load_data,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [15:0] wr_data,
	output logic             strobe,
	output logic [3:0]       reg_index,
	output logic [7:0]       reg_value,
	output logic             last,
	output logic             playing
);

	state_t state_q, state_d;

	logic [9:0]  start_q [3];
	logic [15:0] env_period_q;
	logic [3:0]  env_shape_q;
	logic        loop_q;

	logic [7:0]  mem [TUNE_DEPTH];
	logic [7:0]  rd_data_q;

	logic [TUNE_AW-1:0] pos_q [3];
	logic [7:0]  ticks_q [3];
	logic [2:0]  active_q;
	logic [5:0]  mix_q;
	logic        running_q;
	logic        alive_q;
	logic        stop_mode_q;
	logic [1:0]  trk_q;
	logic [7:0]  note_q;

	logic [11:0] wbuf [MAX_WRITES];
	logic [WCNT_W-1:0] cnt_q;
	logic [WCNT_W-1:0] rd_q;

	logic        accept;
	logic        mem_rd;
	logic        emit_en;
	logic [3:0]  emit_idx;
	logic [7:0]  emit_val;
	logic        trk_inc;
	logic [11:0] per;
	logic [5:0]  trk_bit;
	logic [5:0]  noise_bit;
	logic [5:0]  mix_on;
	logic [5:0]  mix_off;
	logic [3:0]  amp_idx;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign per = tone_period(note_q);
	assign trk_bit = 6'(6'd1 << trk_q);
	assign noise_bit = 6'(6'd8 << trk_q);
	assign mix_on = (mix_q & ~trk_bit) | noise_bit;
	assign mix_off = mix_q | trk_bit | noise_bit;
	assign amp_idx = 4'(REG_AMP0 + {2'b00, trk_q});

	assign reg_index = wbuf[rd_q[WCNT_W-1:0]][11:8];
	assign reg_value = wbuf[rd_q[WCNT_W-1:0]][7:0];
	assign playing = running_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_rd = 1'b0;
		emit_en = 1'b0;
		emit_idx = '0;
		emit_val = '0;
		trk_inc = 1'b0;
		strobe = 1'b0;
		last = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op_t'(op))
						OP_TICK: state_d = running_q ? S_TRK : S_IDLE;
						OP_LOAD: state_d = S_IDLE;
						OP_PLAY: state_d = S_PLAY11;
						OP_STOP: state_d = S_SIL_AMP;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_TRK: begin
				if (active_q[trk_q] && ticks_q[trk_q] == 8'd0) begin
					mem_rd = 1'b1;
					state_d = S_NOTE;
				end else if (trk_q == 2'd2) begin
					state_d = S_END_CHK;
				end else begin
					trk_inc = 1'b1;
					state_d = S_TRK;
				end
			end
			S_NOTE: begin
				if (rd_data_q == END_CODE) begin
					state_d = S_SIL_AMP;
				end else begin
					mem_rd = 1'b1;
					state_d = S_DUR;
				end
			end
			S_DUR: begin
				state_d = (note_q == REST_CODE) ? S_SIL_AMP : S_PLO;
			end
			S_PLO: begin
				emit_en = 1'b1;
				emit_idx = {1'b0, trk_q, 1'b0};
				emit_val = per[7:0];
				state_d = S_PHI;
			end
			S_PHI: begin
				emit_en = 1'b1;
				emit_idx = {1'b0, trk_q, 1'b1};
				emit_val = {4'h0, per[11:8]};
				state_d = S_MIXON;
			end
			S_MIXON: begin
				emit_en = 1'b1;
				emit_idx = REG_MIXER;
				emit_val = {2'b00, mix_on};
				state_d = S_AMP;
			end
			S_AMP: begin
				emit_en = 1'b1;
				emit_idx = amp_idx;
				emit_val = {3'b000, ENV_AMP_CODE};
				state_d = S_SHAPE;
			end
			S_SHAPE: begin
				emit_en = 1'b1;
				emit_idx = REG_SHAPE;
				emit_val = {4'h0, env_shape_q};
				if (trk_q == 2'd2) begin
					state_d = S_END_CHK;
				end else begin
					trk_inc = 1'b1;
					state_d = S_TRK;
				end
			end
			S_SIL_AMP: begin
				emit_en = 1'b1;
				emit_idx = amp_idx;
				emit_val = 8'h00;
				state_d = S_SIL_MIX;
			end
			S_SIL_MIX: begin
				emit_en = 1'b1;
				emit_idx = REG_MIXER;
				emit_val = {2'b00, mix_off};
				if (trk_q == 2'd2) begin
					state_d = stop_mode_q ? S_DRAIN : S_END_CHK;
				end else begin
					trk_inc = 1'b1;
					state_d = stop_mode_q ? S_SIL_AMP : S_TRK;
				end
			end
			S_END_CHK: begin
				if (alive_q) begin
					state_d = S_DRAIN;
				end else if (loop_q) begin
					state_d = S_PLAY11;
				end else begin
					state_d = S_SIL_AMP;
				end
			end
			S_PLAY11: begin
				emit_en = 1'b1;
				emit_idx = REG_ENV_LO;
				emit_val = env_period_q[7:0];
				state_d = S_PLAY12;
			end
			S_PLAY12: begin
				emit_en = 1'b1;
				emit_idx = REG_ENV_HI;
				emit_val = env_period_q[15:8];
				state_d = S_PLAY13;
			end
			S_PLAY13: begin
				emit_en = 1'b1;
				emit_idx = REG_SHAPE;
				emit_val = {4'h0, env_shape_q};
				state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (rd_q == cnt_q) begin
					state_d = S_IDLE;
				end else begin
					strobe = 1'b1;
					if (WCNT_W'(rd_q + 1'b1) == cnt_q) begin
						last = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				start_q[i] <= '0;
			end
			env_period_q <= '0;
			env_shape_q <= '0;
			loop_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_TRACK0: start_q[0] <= wr_data[9:0];
				CFG_TRACK1: start_q[1] <= wr_data[9:0];
				CFG_TRACK2: start_q[2] <= wr_data[9:0];
				CFG_ENV_PERIOD: env_period_q <= wr_data;
				CFG_ENV_SHAPE: env_shape_q <= wr_data[3:0];
				CFG_LOOP: loop_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op_t'(op) == OP_LOAD) begin
			mem[TUNE_AW'(32'(load_addr))] <= load_data;
		end
		if (mem_rd) begin
			rd_data_q <= mem[pos_q[trk_q]];
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			wbuf[cnt_q] <= {emit_idx, emit_val};
		end
		if (state_q == S_NOTE) begin
			note_q <= rd_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				ticks_q[i] <= '0;
			end
			active_q <= '0;
			mix_q <= 6'h3F;
			running_q <= 1'b0;
			alive_q <= 1'b0;
			stop_mode_q <= 1'b0;
			trk_q <= '0;
			cnt_q <= '0;
			rd_q <= '0;
		end else begin
			if (emit_en) begin
				cnt_q <= WCNT_W'(cnt_q + 1'b1);
			end
			if (trk_inc) begin
				trk_q <= 2'(trk_q + 2'd1);
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						rd_q <= '0;
						trk_q <= '0;
						alive_q <= 1'b0;
						stop_mode_q <= (op_t'(op) == OP_STOP);
						if (op_t'(op) == OP_STOP) begin
							running_q <= 1'b0;
						end
					end
				end
				S_TRK: begin
					if (active_q[trk_q]) begin
						if (ticks_q[trk_q] != 8'd0) begin
							ticks_q[trk_q] <= 8'(ticks_q[trk_q] - 8'd1);
							alive_q <= 1'b1;
						end else begin
							pos_q[trk_q] <= TUNE_AW'(pos_q[trk_q] + 1'b1);
						end
					end
				end
				S_NOTE: begin
					if (rd_data_q == END_CODE) begin
						active_q[trk_q] <= 1'b0;
					end else begin
						pos_q[trk_q] <= TUNE_AW'(pos_q[trk_q] + 1'b1);
					end
				end
				S_DUR: begin
					ticks_q[trk_q] <= (rd_data_q != 8'd0) ? 8'(rd_data_q - 8'd1) : 8'd0;
					alive_q <= 1'b1;
				end
				S_MIXON: mix_q <= mix_on;
				S_SIL_MIX: mix_q <= mix_off;
				S_END_CHK: begin
					if (!alive_q && !loop_q) begin
						running_q <= 1'b0;
						stop_mode_q <= 1'b1;
						trk_q <= '0;
					end
				end
				S_PLAY11: begin
					for (int i = 0; i < 3; i++) begin
						pos_q[i] <= TUNE_AW'(32'(start_q[i]));
						ticks_q[i] <= '0;
					end
					active_q <= 3'b111;
				end
				S_PLAY13: running_q <= 1'b1;
				S_DRAIN: begin
					if (strobe) begin
						rd_q <= WCNT_W'(rd_q + 1'b1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/tns_checker.sv @@
`default_nettype none
module tns_checker import tns_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] op,
	input wire logic       strobe,
	input wire logic       last
);

	// A write is only ever shown while a request is still being handled.
	assert property (@(posedge clk) disable iff (!arst_n) strobe |-> busy)
		else $error("write strobe while not busy");

	assert property (@(posedge clk) disable iff (!arst_n) last |-> strobe)
		else $error("last flag without a write");

	// The writes of one request come out in an unbroken burst.
	assert property (@(posedge clk) disable iff (!arst_n) strobe && !last |=> strobe)
		else $error("gap inside a write burst");

	assert property (@(posedge clk) disable iff (!arst_n) strobe && last |=> !strobe)
		else $error("write after the last one of a burst");

	// A load request causes no writes and completes at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op == OP_LOAD |=> !busy && !strobe)
		else $error("load request did not complete in one cycle");

endmodule

bind three_track_note_sequencer tns_checker u_tns_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.op(op),
	.strobe(strobe),
	.last(last)
);
`default_nettype wire
